FILE: sv/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg: shared types, constants and calendar functions
// Holds the unit codes, the sequencer states, the leap-year request struct
// and the month-length and leap-year functions used by the date subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

package cds_pkg;

   localparam int unsigned YEAR_W  = 16;
   localparam int unsigned YEAR_IW = 17;   // working year, one bit of headroom
   localparam int unsigned DIFF_W  = 22;   // year minus up to 1023 millennia
   localparam int unsigned PROD_W  = 20;   // amount times unit, up to 1023000
   localparam int unsigned AMT_W   = 10;
   localparam int unsigned REM_W   = 13;   // up to 1023 weeks in days
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [DAY_W-1:0] DAYS_LONG     = 5'd31;
   localparam logic [DAY_W-1:0] DAYS_SHORT    = 5'd30;
   localparam logic [DAY_W-1:0] DAYS_FEB      = 5'd28;
   localparam logic [DAY_W-1:0] DAYS_FEB_LEAP = 5'd29;

   localparam logic signed [YEAR_IW-1:0] YEAR_MIN_I = -17'sd32768;
   localparam logic signed [DIFF_W-1:0]  YEAR_MIN_D = -22'sd32768;

   typedef enum logic [2:0] {
      OP_DAY        = 3'd0,
      OP_WEEK       = 3'd1,
      OP_MONTH      = 3'd2,
      OP_YEAR       = 3'd3,
      OP_DECADE     = 3'd4,
      OP_CENTURY    = 3'd5,
      OP_MILLENNIUM = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEAP,
      ST_FIX,
      ST_DAY_STEP,
      ST_MONTH_STEP,
      ST_YEAR_MUL,
      ST_YEAR_SUB,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                     load;
      logic signed [YEAR_IW-1:0] year;
   } cds_leap_req_type;

   // Days in a month; month codes outside 1..12 give 31.
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      begin
         len = DAYS_LONG;
         if (m == MONTH_FEB) begin
            len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
         end else if ((m == MONTH_APR) || (m == MONTH_JUN) ||
                      (m == MONTH_SEP) || (m == MONTH_NOV)) begin
            len = DAYS_SHORT;
         end
         return len;
      end
   endfunction

   // Gregorian rule on the magnitude of the year. Divisibility by 25 folds the
   // value with 1024 = -1 (mod 25) and finishes with a reciprocal multiply.
   function automatic logic is_leap(input logic signed [YEAR_IW-1:0] y);
      logic [YEAR_IW-1:0] mag;
      logic [10:0]        t1;
      logic [10:0]        t2;
      logic [16:0]        prod;
      logic [10:0]        q;
      logic [10:0]        q25;
      logic               d4;
      logic               d16;
      logic               d25;
      begin
         mag  = y[YEAR_IW-1] ? YEAR_IW'(-y) : YEAR_IW'(y);
         t1   = {1'b0, mag[9:0]} + 11'd1000 - {4'b0, mag[16:10]};
         t2   = {1'b0, t1[9:0]} + 11'd25 - {10'b0, t1[10]};
         prod = {6'b0, t2} * 17'd41;
         q    = {5'b0, prod[15:10]};
         q25  = (q << 4) + (q << 3) + q;
         d25  = (q25 == t2);
         d4   = (mag[1:0] == 2'b00);
         d16  = (mag[3:0] == 4'b0000);
         return (d16 && d25) || (d4 && !d25);
      end
   endfunction

endpackage : cds_pkg

`default_nettype wire

FILE: sv/calendar_date_subtract_core.sv
// ----------------------------------------------------------------------------
// calendar_date_subtract_core: Gregorian date minus an amount of units
// Subtracts days, weeks, months or whole years, decades, centuries or
// millennia from a date, clamping the day to the month length, and flags
// a year that would fall below -32768.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+---------------------------------
//   req     | in        | req_valid / req_ready  | op, amount, year_in, month_in, day_in
//   rsp     | out       | rsp_valid / rsp_ready  | year_out, month_out, day_out, underflow
//
// The year units step through leap check, clamp, multiply, subtract, leap
// check, clamp and done. Days, weeks and months walk back one month per
// cycle within a year through a single subtract-and-compare step; every
// year boundary crossed adds a leap check and a clamp. Reset is
// synchronous and clears the sequencer and the result valid flag. The block
// takes a new transfer whenever the sequencer is idle, even while the
// previous result still waits; a finished result then holds in the last
// state until the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_subtract_core (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_op,
   input  wire logic [9:0]  req_amount,
   input  wire logic [15:0] req_year_in,
   input  wire logic [3:0]  req_month_in,
   input  wire logic [4:0]  req_day_in,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_year_out,
   output logic [3:0]       rsp_month_out,
   output logic [4:0]       rsp_day_out,
   output logic             rsp_underflow
);
   import cds_pkg::*;

   // Sequencer and working registers.
   state_type                state_ff,  state_in;
   op_type                   op_ff,     op_in;
   logic [AMT_W-1:0]         amt_ff,    amt_in;
   logic signed [YEAR_IW-1:0] year_ff,  year_in;
   logic [MONTH_W-1:0]       month_ff,  month_in;
   logic [DAY_W-1:0]         day_ff,    day_in;
   logic [REM_W-1:0]         rem_ff,    rem_in;
   logic [PROD_W-1:0]        prod_ff,   prod_in;
   logic                     init_ff,   init_in;
   logic                     uflow_ff,  uflow_in;

   // The starting date after clamping, returned on underflow.
   logic [YEAR_W-1:0]        y0_ff,     y0_in;
   logic [MONTH_W-1:0]       m0_ff,     m0_in;
   logic [DAY_W-1:0]         d0_ff,     d0_in;

   // Result register.
   logic                     rsp_valid_ff,  rsp_valid_in;
   logic [YEAR_W-1:0]        rsp_year_ff,   rsp_year_in;
   logic [MONTH_W-1:0]       rsp_month_ff,  rsp_month_in;
   logic [DAY_W-1:0]         rsp_day_ff,    rsp_day_in;
   logic                     rsp_uflow_ff,  rsp_uflow_in;

   cds_leap_req_type         leap_req;
   logic                     leap;
   logic [DAY_W-1:0]         cur_len;
   logic [DAY_W-1:0]         prev_len;
   logic [MONTH_W-1:0]       prev_month;
   logic [DAY_W-1:0]         clamped_day;
   logic signed [DIFF_W-1:0] year_diff;
   logic [PROD_W-1:0]        unit_prod;
   logic                     final_uflow;

   cds_leap u_leap (
      .clock    (clock),
      .leap_req (leap_req),
      .leap     (leap)
   );

   // Month lengths for the current month and for the one before it in the
   // same year; whenever a length is used, the leap flag belongs to the working year.
   assign prev_month  = month_ff - 4'd1;
   assign cur_len     = month_len(month_ff, leap);
   assign prev_len    = month_len(prev_month, leap);
   assign clamped_day = (day_ff > cur_len) ? cur_len : day_ff;

   assign year_diff = {{(DIFF_W-YEAR_W){y0_ff[YEAR_W-1]}}, y0_ff}
                      - {{(DIFF_W-PROD_W){1'b0}}, prod_ff};
   assign final_uflow = uflow_ff || (year_ff < YEAR_MIN_I);

   // Amount times the unit in years, built from shifts, adds and subtracts.
   always_comb begin
      unit_prod = {{(PROD_W-AMT_W){1'b0}}, amt_ff};
      unique case (op_ff)
         OP_DECADE: begin
            unit_prod = (PROD_W'(amt_ff) << 3) + (PROD_W'(amt_ff) << 1);
         end
         OP_CENTURY: begin
            unit_prod = (PROD_W'(amt_ff) << 6) + (PROD_W'(amt_ff) << 5)
                        + (PROD_W'(amt_ff) << 2);
         end
         OP_MILLENNIUM: begin
            unit_prod = (PROD_W'(amt_ff) << 10) - (PROD_W'(amt_ff) << 4)
                        - (PROD_W'(amt_ff) << 3);
         end
         default: begin
            unit_prod = {{(PROD_W-AMT_W){1'b0}}, amt_ff};
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      amt_in        = amt_ff;
      year_in       = year_ff;
      month_in      = month_ff;
      day_in        = day_ff;
      rem_in        = rem_ff;
      prod_in       = prod_ff;
      init_in       = init_ff;
      uflow_in      = uflow_ff;
      y0_in         = y0_ff;
      m0_in         = m0_ff;
      d0_in         = d0_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_year_in   = rsp_year_ff;
      rsp_month_in  = rsp_month_ff;
      rsp_day_in    = rsp_day_ff;
      rsp_uflow_in  = rsp_uflow_ff;
      leap_req.load = 1'b0;
      leap_req.year = year_ff;
      req_ready     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // Out-of-range month and a zero day are pulled into range here;
               // the day is clamped to the month length once the leap flag is in.
               op_in    = op_type'(req_op);
               amt_in   = req_amount;
               year_in  = {req_year_in[YEAR_W-1], req_year_in};
               y0_in    = req_year_in;
               if (req_month_in < MONTH_JAN) begin
                  month_in = MONTH_JAN;
               end else if (req_month_in > MONTH_DEC) begin
                  month_in = MONTH_DEC;
               end else begin
                  month_in = req_month_in;
               end
               m0_in    = month_in;
               day_in   = (req_day_in == 5'd0) ? 5'd1 : req_day_in;
               init_in  = 1'b1;
               uflow_in = 1'b0;
               state_in = ST_LEAP;
            end
         end

         ST_LEAP: begin
            leap_req.load = 1'b1;
            state_in      = ST_FIX;
         end

         ST_FIX: begin
            if (init_ff) begin
               day_in  = clamped_day;
               d0_in   = clamped_day;
               init_in = 1'b0;
               priority case (op_ff)
                  OP_DAY: begin
                     rem_in   = {{(REM_W-AMT_W){1'b0}}, amt_ff};
                     state_in = ST_DAY_STEP;
                  end
                  OP_WEEK: begin
                     rem_in   = (REM_W'(amt_ff) << 3) - REM_W'(amt_ff);
                     state_in = ST_DAY_STEP;
                  end
                  OP_MONTH: begin
                     rem_in   = {{(REM_W-AMT_W){1'b0}}, amt_ff};
                     state_in = ST_MONTH_STEP;
                  end
                  OP_YEAR, OP_DECADE, OP_CENTURY, OP_MILLENNIUM: begin
                     state_in = ST_YEAR_MUL;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end else begin
               priority case (op_ff)
                  OP_DAY, OP_WEEK: begin
                     // A year boundary was crossed: land on 31 December's length.
                     day_in   = cur_len;
                     state_in = ST_DAY_STEP;
                  end
                  OP_MONTH: begin
                     day_in   = clamped_day;
                     state_in = ST_MONTH_STEP;
                  end
                  default: begin
                     day_in   = clamped_day;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_DAY_STEP: begin
            // Either consume the whole current month or finish inside it.
            if (rem_ff == '0) begin
               state_in = ST_DONE;
            end else if (rem_ff >= {{(REM_W-DAY_W){1'b0}}, day_ff}) begin
               rem_in = rem_ff - {{(REM_W-DAY_W){1'b0}}, day_ff};
               if (month_ff <= MONTH_JAN) begin
                  month_in = MONTH_DEC;
                  year_in  = year_ff - 17'sd1;
                  state_in = ST_LEAP;
               end else begin
                  month_in = prev_month;
                  day_in   = prev_len;
               end
            end else begin
               day_in   = day_ff - rem_ff[DAY_W-1:0];
               rem_in   = '0;
               state_in = ST_DONE;
            end
         end

         ST_MONTH_STEP: begin
            if (rem_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               rem_in = rem_ff - REM_W'(1);
               if (month_ff <= MONTH_JAN) begin
                  month_in = MONTH_DEC;
                  year_in  = year_ff - 17'sd1;
                  state_in = ST_LEAP;
               end else begin
                  month_in = prev_month;
                  day_in   = (day_ff > prev_len) ? prev_len : day_ff;
               end
            end
         end

         ST_YEAR_MUL: begin
            prod_in  = unit_prod;
            state_in = ST_YEAR_SUB;
         end

         ST_YEAR_SUB: begin
            if (year_diff < YEAR_MIN_D) begin
               uflow_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               year_in  = year_diff[YEAR_IW-1:0];
               state_in = ST_LEAP;
            end
         end

         ST_DONE: begin
            // Hold here until the result register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_uflow_in = final_uflow;
               if (final_uflow) begin
                  rsp_year_in  = y0_ff;
                  rsp_month_in = m0_ff;
                  rsp_day_in   = d0_ff;
               end else begin
                  rsp_year_in  = year_ff[YEAR_W-1:0];
                  rsp_month_in = month_ff;
                  rsp_day_in   = day_ff;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      amt_ff       <= amt_in;
      year_ff      <= year_in;
      month_ff     <= month_in;
      day_ff       <= day_in;
      rem_ff       <= rem_in;
      prod_ff      <= prod_in;
      init_ff      <= init_in;
      uflow_ff     <= uflow_in;
      y0_ff        <= y0_in;
      m0_ff        <= m0_in;
      d0_ff        <= d0_in;
      rsp_year_ff  <= rsp_year_in;
      rsp_month_ff <= rsp_month_in;
      rsp_day_ff   <= rsp_day_in;
      rsp_uflow_ff <= rsp_uflow_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_year_out  = rsp_year_ff;
   assign rsp_month_out = rsp_month_ff;
   assign rsp_day_out   = rsp_day_ff;
   assign rsp_underflow = rsp_uflow_ff;

   // An accepted transfer always starts with the leap check of its year.
   a_accept_starts_leap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_LEAP))
      else $error("accepted transfer did not start the leap check");

   // The working month stays a real month while an item is in progress.
   a_month_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> ((month_ff >= MONTH_JAN) && (month_ff <= MONTH_DEC)))
      else $error("working month left the range 1 to 12");

   // The day walk never sees a zero day.
   a_day_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DAY_STEP) |-> (day_ff != 5'd0))
      else $error("day walk reached day zero");

   // Every delivered date is a valid calendar position.
   a_result_valid_date: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_day_out != 5'd0) && (rsp_month_out >= MONTH_JAN) &&
                     (rsp_month_out <= MONTH_DEC)))
      else $error("result date out of range");

endmodule : calendar_date_subtract_core

`default_nettype wire

FILE: sv/cds_leap.sv
// ----------------------------------------------------------------------------
// cds_leap: registered leap-year flag
// Evaluates the Gregorian leap rule for the working year when asked and
// holds the answer until the next request.
// ----------------------------------------------------------------------------
`default_nettype none

module cds_leap (
   input  wire logic                      clock,
   input  wire cds_pkg::cds_leap_req_type leap_req,
   output logic                           leap
);
   import cds_pkg::*;

   logic leap_ff;
   logic leap_in;

   always_comb begin
      leap_in = leap_ff;
      if (leap_req.load) begin
         leap_in = is_leap(leap_req.year);
      end
   end

   always_ff @(posedge clock) begin
      leap_ff <= leap_in;
   end

   assign leap = leap_ff;

endmodule : cds_leap

`default_nettype wire
